// ===== src/ready_delay_thread_scheduler_macros.svh =====
// ============================================================================
// Assertion macros for the ready delay thread scheduler
// Shared helpers for concurrent checks clocked on clk with synchronous rst.
// ============================================================================
`ifndef READY_DELAY_THREAD_SCHEDULER_MACROS_SVH
`define READY_DELAY_THREAD_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RDTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RDTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rdts_pkg.sv =====
// ============================================================================
// rdts_pkg
// Types and constants shared by the ready delay thread scheduler modules.
// ============================================================================
package rdts_pkg;

  localparam int NUM_THREADS = 32;
  localparam int PRIO_W      = 6;
  localparam int TICK_W      = 32;
  localparam int IDX_W       = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int CNT_W       = $clog2(NUM_THREADS + 1);

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_DELAY = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [PRIO_W-1:0] thread_prio;
    logic [TICK_W-1:0] delay_ticks;
  } item_t;

  typedef struct packed {
    logic [PRIO_W-1:0] next_thread;
    logic              switch_needed;
    logic              delay_error;
  } result_t;

endpackage

// ===== src/rdts_ram.sv =====
// ============================================================================
// rdts_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
module rdts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                   wdata,
  input  logic                               re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rdts_prio_enc.sv =====
// ============================================================================
// rdts_prio_enc
// Finds the highest set bit of the ready set and returns its priority.
// ============================================================================
module rdts_prio_enc import rdts_pkg::*; (
  input  logic [NUM_THREADS-1:0] mask,
  output logic [PRIO_W-1:0]      prio
);

  always_comb begin
    prio = '0;
    for (int i = 0; i < NUM_THREADS; i++) begin
      if (mask[i]) begin
        prio = PRIO_W'(i + 1);
      end
    end
  end

endmodule

// ===== src/ready_delay_thread_scheduler.sv =====
// ============================================================================
// ready_delay_thread_scheduler
// Priority thread scheduler with per-thread tick delays held in a RAM.
// Start, delay and unused actions go from the idle state through the
// scheduling step to the result; a tick sweeps all timeout entries through
// one RAM port in the tick state before the scheduling step.
// One item is in flight at a time and the next is accepted the cycle after
// its result loads; the load waits while an earlier result is still untaken.
// Reset clears both thread sets and makes the idle thread current.
// ============================================================================
module ready_delay_thread_scheduler import rdts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  `include "ready_delay_thread_scheduler_macros.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TICK  = 2'd1;
  localparam logic [1:0] ST_SCHED = 2'd2;

  logic [1:0]             state;
  logic [CNT_W-1:0]       cnt;
  logic                   rv;
  logic [IDX_W-1:0]       rv_idx;
  logic                   err;
  logic [NUM_THREADS-1:0] ready_mask;
  logic [NUM_THREADS-1:0] delayed_mask;
  logic [PRIO_W-1:0]      current;

  logic                   accept;
  logic                   cur_valid;
  logic [IDX_W-1:0]       cur_idx;
  logic                   start_valid;
  logic [IDX_W-1:0]       start_idx;
  logic                   sweep_rd;
  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [TICK_W-1:0]      wdata;
  logic [TICK_W-1:0]      rdata;
  logic [PRIO_W-1:0]      sched_next;
  logic                   load;

  assign item_ready  = (state == ST_IDLE);
  assign accept      = item_valid && item_ready;
  assign cur_valid   = (current != '0) && (current <= PRIO_W'(NUM_THREADS));
  assign cur_idx     = IDX_W'(current - PRIO_W'(1));
  assign start_valid = (item.thread_prio != '0)
                       && (item.thread_prio <= PRIO_W'(NUM_THREADS));
  assign start_idx   = IDX_W'(item.thread_prio - PRIO_W'(1));
  assign sweep_rd    = (state == ST_TICK) && (cnt != CNT_W'(NUM_THREADS));
  assign load        = (state == ST_SCHED) && (!result_valid || result_ready);

  always_comb begin
    we    = 1'b0;
    waddr = cur_idx;
    wdata = item.delay_ticks;
    if (accept && item.action == ACT_DELAY && cur_valid) begin
      we = 1'b1;
    end else if (rv && delayed_mask[rv_idx]) begin
      we    = 1'b1;
      waddr = rv_idx;
      wdata = (rdata <= TICK_W'(1)) ? '0 : rdata - TICK_W'(1);
    end
  end

  rdts_ram #(
    .WIDTH (TICK_W),
    .DEPTH (NUM_THREADS)
  ) u_timeout_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (sweep_rd),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rdata)
  );

  rdts_prio_enc u_prio_enc (
    .mask (ready_mask),
    .prio (sched_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      rv           <= 1'b0;
      err          <= 1'b0;
      ready_mask   <= '0;
      delayed_mask <= '0;
      current      <= '0;
      result_valid <= 1'b0;
    end else begin
      rv     <= sweep_rd;
      rv_idx <= cnt[IDX_W-1:0];
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            err <= 1'b0;
            cnt <= '0;
            state <= ST_SCHED;
            unique case (item.action)
              ACT_TICK: begin
                state <= ST_TICK;
              end
              ACT_DELAY: begin
                if (current == '0) begin
                  err <= 1'b1;
                end else if (cur_valid) begin
                  ready_mask[cur_idx]   <= 1'b0;
                  delayed_mask[cur_idx] <= 1'b1;
                end
              end
              ACT_START: begin
                if (start_valid) begin
                  ready_mask[start_idx] <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_TICK: begin
          if (rv && delayed_mask[rv_idx] && rdata <= TICK_W'(1)) begin
            ready_mask[rv_idx]   <= 1'b1;
            delayed_mask[rv_idx] <= 1'b0;
          end
          if (cnt == CNT_W'(NUM_THREADS)) begin
            state <= ST_SCHED;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_SCHED: begin
          if (load) begin
            result.next_thread   <= sched_next;
            result.switch_needed <= (sched_next != current);
            result.delay_error   <= err;
            result_valid         <= 1'b1;
            current              <= sched_next;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `RDTS_ASSERT_NEXT(a_sweep_ends, (state == ST_TICK) && (cnt == CNT_W'(NUM_THREADS)), (state == ST_SCHED) && !rv, "tick sweep did not end in the scheduling step")
  `RDTS_ASSERT_NOW(a_idle_no_read, item_ready, !rv, "RAM read pending while idle")
  `RDTS_ASSERT_NOW(a_next_is_ready, load && (sched_next != '0), ready_mask[IDX_W'(sched_next - PRIO_W'(1))], "selected thread is not ready")
  `RDTS_ASSERT_NOW(a_err_from_idle, load && err, current == '0, "delay error without idle thread current")
  `RDTS_ASSERT_NEXT(a_load_shows, load, result_valid && (current == result.next_thread), "result transfer not presented after load")

endmodule

// ===== tb/sv/ready_delay_thread_scheduler_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// ready_delay_thread_scheduler_tb
// Drives start, delay, tick and unused-code transfers into the scheduler, runs
// a scoreboard model of the ready and delayed thread sets, and compares every
// result transfer with the next expected schedule decision. Both channels
// stall in short random bursts except in the final stretch of the run.
// ============================================================================
module ready_delay_thread_scheduler_tb;
  import rdts_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int NUM_DIRECTED   = 21;
  localparam int RANDOM_ITEMS   = 1030;
  localparam int TAIL_ITEMS     = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    item_t   stim;
    bit      typed;
    result_t want;
  } directed_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  logic [NUM_THREADS-1:0] sched_ready = '0;
  logic [NUM_THREADS-1:0] sched_delayed = '0;
  logic [TICK_W-1:0]      sched_timeout [NUM_THREADS];
  logic [PRIO_W-1:0]      sched_current = '0;

  result_t expected_results [$];
  int      error_count = 0;
  int      quiet_cycles = 0;
  int      stall_left = 0;
  bit      steady_tail = 1'b0;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{ACT_TICK,   6'd0,  32'd0},           1'b1, '{6'd0,  1'b0, 1'b0}},
    '{'{ACT_DELAY,  6'd0,  32'hFFFF_FFFF},   1'b1, '{6'd0,  1'b0, 1'b1}},
    '{'{ACT_UNUSED, 6'd63, 32'hFFFF_FFFF},   1'b1, '{6'd0,  1'b0, 1'b0}},
    '{'{ACT_START,  6'd0,  32'd0},           1'b1, '{6'd0,  1'b0, 1'b0}},
    '{'{ACT_START,  6'd33, 32'd0},           1'b1, '{6'd0,  1'b0, 1'b0}},
    '{'{ACT_START,  6'd63, 32'hFFFF_FFFF},   1'b1, '{6'd0,  1'b0, 1'b0}},
    '{'{ACT_START,  6'd1,  32'd0},           1'b1, '{6'd1,  1'b1, 1'b0}},
    '{'{ACT_START,  6'd32, 32'd0},           1'b1, '{6'd32, 1'b1, 1'b0}},
    '{'{ACT_START,  6'd32, 32'd0},           1'b1, '{6'd32, 1'b0, 1'b0}},
    '{'{ACT_DELAY,  6'd0,  32'd0},           1'b0, '0},
    '{'{ACT_TICK,   6'd0,  32'd0},           1'b0, '0},
    '{'{ACT_DELAY,  6'd0,  32'd2},           1'b0, '0},
    '{'{ACT_START,  6'd32, 32'd0},           1'b0, '0},
    '{'{ACT_TICK,   6'd0,  32'd0},           1'b0, '0},
    '{'{ACT_TICK,   6'd0,  32'd0},           1'b0, '0},
    '{'{ACT_DELAY,  6'd0,  32'hFFFF_FFFF},   1'b0, '0},
    '{'{ACT_DELAY,  6'd0,  32'd1},           1'b0, '0},
    '{'{ACT_TICK,   6'd0,  32'd0},           1'b0, '0},
    '{'{ACT_START,  6'd16, 32'd0},           1'b0, '0},
    '{'{ACT_DELAY,  6'd0,  32'h8000_0000},   1'b0, '0},
    '{'{ACT_START,  6'd32, 32'd0},           1'b0, '0}
  };

  ready_delay_thread_scheduler DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic predict_schedule(input item_t it, output result_t r);
    logic [PRIO_W-1:0] pick;
    logic              err;
    pick = '0;
    err  = 1'b0;
    case (it.action)
      ACT_TICK: begin
        for (int p = 0; p < NUM_THREADS; p++) begin
          if (sched_delayed[p]) begin
            if (sched_timeout[p] <= 1) begin
              sched_timeout[p] = '0;
              sched_ready[p]   = 1'b1;
              sched_delayed[p] = 1'b0;
            end else begin
              sched_timeout[p] = sched_timeout[p] - 1'b1;
            end
          end
        end
      end
      ACT_DELAY: begin
        if (sched_current == 0) begin
          err = 1'b1;
        end else if (sched_current <= NUM_THREADS) begin
          sched_timeout[sched_current - 1] = it.delay_ticks;
          sched_ready[sched_current - 1]   = 1'b0;
          sched_delayed[sched_current - 1] = 1'b1;
        end
      end
      ACT_START: begin
        if (it.thread_prio >= 1 && it.thread_prio <= NUM_THREADS) begin
          sched_ready[it.thread_prio - 1] = 1'b1;
        end
      end
      default: ;
    endcase
    for (int p = NUM_THREADS; p >= 1; p--) begin
      if (sched_ready[p - 1] && pick == 0) begin
        pick = PRIO_W'(p);
      end
    end
    r.next_thread   = pick;
    r.switch_needed = (pick != sched_current);
    r.delay_error   = err;
    sched_current   = pick;
  endtask

  function automatic item_t random_item();
    item_t it;
    int    pick;
    it.thread_prio = PRIO_W'($urandom);
    it.delay_ticks = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.action = ACT_TICK;
    end else if (pick < 65) begin
      it.action = ACT_DELAY;
      if ($urandom_range(0, 19) != 0) begin
        it.delay_ticks = $urandom_range(0, 6);
      end
    end else if (pick < 95) begin
      it.action = ACT_START;
      if ($urandom_range(0, 19) != 0) begin
        it.thread_prio = PRIO_W'($urandom_range(1, NUM_THREADS));
      end
    end else begin
      it.action = ACT_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(input item_t it, input bit typed, input result_t want);
    result_t predicted;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    predict_schedule(it, predicted);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic idle_sender();
    if (!steady_tail && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst || steady_tail) begin
      result_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: next_thread %0d",
                                  result.next_thread));
      end else begin
        want = expected_results.pop_front();
        if (result.next_thread !== want.next_thread) begin
          report_mismatch($sformatf("next_thread got %0d expected %0d",
                                    result.next_thread, want.next_thread));
        end
        if (result.switch_needed !== want.switch_needed) begin
          report_mismatch($sformatf("switch_needed got %b expected %b",
                                    result.switch_needed, want.switch_needed));
        end
        if (result.delay_error !== want.delay_error) begin
          report_mismatch($sformatf("delay_error got %b expected %b",
                                    result.delay_error, want.delay_error));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
      idle_sender();
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_item(random_item(), 1'b0, '0);
      if (i == RANDOM_ITEMS / 2) begin
        item_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
      end else begin
        if (i >= RANDOM_ITEMS - TAIL_ITEMS) begin
          steady_tail = 1'b1;
        end
        idle_sender();
      end
    end
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/rdts_pkg.sv
src/rdts_ram.sv
src/rdts_prio_enc.sv
src/ready_delay_thread_scheduler.sv
tb/sv/ready_delay_thread_scheduler_tb.sv
